FILE: rtl/mfd_pkg.sv
// Shared constants and RAM request types for the max-flow augmenting-path block.
// No dependencies; every other file but mfd_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none
package mfd_pkg;
	localparam int VERT_BITS    = 6;
	localparam int MAX_VERTICES = 1 << VERT_BITS;
	localparam int CNT_BITS     = VERT_BITS + 1;
	localparam int CAP_BITS     = 16;
	localparam int FLOW_BITS    = 22;
	localparam int RES_ABITS    = 2 * VERT_BITS;
	localparam int RES_DEPTH    = 1 << RES_ABITS;
	localparam int STK_BITS     = VERT_BITS + CNT_BITS;
	localparam int CFG_IBITS    = 2;
	localparam int CFG_DBITS    = 7;

	localparam logic [FLOW_BITS-1:0] FLOW_MAX = {FLOW_BITS{1'b1}};
	localparam logic [CAP_BITS-1:0]  CAP_MAX  = {CAP_BITS{1'b1}};

	localparam logic [CFG_IBITS-1:0] CFG_VERTEX_COUNT  = 2'd0;
	localparam logic [CFG_IBITS-1:0] CFG_SOURCE_VERTEX = 2'd1;
	localparam logic [CFG_IBITS-1:0] CFG_SINK_VERTEX   = 2'd2;

	typedef struct packed {
		logic                 we;
		logic [RES_ABITS-1:0] waddr;
		logic [CAP_BITS-1:0]  wdata;
		logic [RES_ABITS-1:0] raddr;
	} res_req_t;

	typedef struct packed {
		logic                 we;
		logic [VERT_BITS-1:0] waddr;
		logic [VERT_BITS-1:0] wdata;
		logic [VERT_BITS-1:0] raddr;
	} par_req_t;

	typedef struct packed {
		logic                 we;
		logic [VERT_BITS-1:0] waddr;
		logic [STK_BITS-1:0]  wdata;
		logic [VERT_BITS-1:0] raddr;
	} stk_req_t;
endpackage
`default_nettype wire

FILE: rtl/mfd_ifs.sv
// Channel interfaces: capacity entry input, flow result output, register write port.
// Depends on mfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mfd_entry_if;
	logic                          valid;
	logic                          ready;
	logic [mfd_pkg::VERT_BITS-1:0] from_vertex;
	logic [mfd_pkg::VERT_BITS-1:0] to_vertex;
	logic [mfd_pkg::CAP_BITS-1:0]  capacity;
	logic                          last_entry;
	modport source(output valid, from_vertex, to_vertex, capacity, last_entry, input ready);
	modport sink(input valid, from_vertex, to_vertex, capacity, last_entry, output ready);
endinterface

interface mfd_result_if;
	logic                          valid;
	logic                          ready;
	logic [mfd_pkg::FLOW_BITS-1:0] total_flow;
	modport source(output valid, total_flow, input ready);
	modport sink(input valid, total_flow, output ready);
endinterface

interface mfd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mfd_pkg::CFG_IBITS-1:0] index;
	logic [mfd_pkg::CFG_DBITS-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/mfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/mfd_engine.sv
// Sequencer for loading, depth-first path search, augmentation and store clearing.
// Depends on mfd_pkg and mfd_ifs; drives the residual, parent and stack RAMs.
`timescale 1ns / 1ps
`default_nettype none
module mfd_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	mfd_entry_if.sink                         entry,
	mfd_result_if.source                      result,
	mfd_cfg_if.sink                           cfg,
	output mfd_pkg::res_req_t                 res_req,
	input  wire logic [mfd_pkg::CAP_BITS-1:0] res_rdata,
	output mfd_pkg::par_req_t                 par_req,
	input  wire logic [mfd_pkg::VERT_BITS-1:0] par_rdata,
	output mfd_pkg::stk_req_t                 stk_req,
	input  wire logic [mfd_pkg::STK_BITS-1:0] stk_rdata
);
	import mfd_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_START = 4'd2;
	localparam logic [3:0] S_INIT  = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_CHECK = 4'd5;
	localparam logic [3:0] S_POPLD = 4'd6;
	localparam logic [3:0] S_BP    = 4'd7;
	localparam logic [3:0] S_BPW   = 4'd8;
	localparam logic [3:0] S_BRW   = 4'd9;
	localparam logic [3:0] S_AP    = 4'd10;
	localparam logic [3:0] S_APW   = 4'd11;
	localparam logic [3:0] S_AW1   = 4'd12;
	localparam logic [3:0] S_AW2   = 4'd13;

	localparam logic [CNT_BITS-1:0]  NMAX    = CNT_BITS'(MAX_VERTICES);
	localparam logic [VERT_BITS-1:0] TOP_MAX = {VERT_BITS{1'b1}};

	logic [3:0]              state_q;
	logic [RES_ABITS-1:0]    clr_q;
	logic [CNT_BITS-1:0]     vc_q;
	logic [VERT_BITS-1:0]    src_q;
	logic [VERT_BITS-1:0]    snk_q;
	logic [VERT_BITS-1:0]    u_q;
	logic [CNT_BITS-1:0]     i_q;
	logic [VERT_BITS-1:0]    top_q;
	logic [MAX_VERTICES-1:0] seen_q;
	logic [VERT_BITS-1:0]    v_q;
	logic [CAP_BITS-1:0]     bn_q;
	logic [FLOW_BITS-1:0]    flow_q;
	logic                    out_valid_q;
	logic [FLOW_BITS-1:0]    out_flow_q;

	logic [CNT_BITS-1:0]  n;
	logic [CNT_BITS-1:0]  i_inc;
	logic                 in_acc;
	logic [CAP_BITS:0]    back_sum;
	logic [FLOW_BITS:0]   flow_sum;
	logic [CAP_BITS-1:0]  back_sat;
	logic [FLOW_BITS-1:0] flow_sat;

	assign n        = (vc_q > NMAX) ? NMAX : vc_q;
	assign i_inc    = i_q + 1'b1;
	assign entry.ready = (state_q == S_IDLE) && (!out_valid_q || !entry.last_entry);
	assign in_acc   = entry.valid && entry.ready;
	assign cfg.ready = 1'b1;
	assign result.valid = out_valid_q;
	assign result.total_flow = out_flow_q;
	assign back_sum = {1'b0, res_rdata} + {1'b0, bn_q};
	assign back_sat = back_sum[CAP_BITS] ? CAP_MAX : back_sum[CAP_BITS-1:0];
	assign flow_sum = {1'b0, flow_q} + {{(FLOW_BITS-CAP_BITS+1){1'b0}}, bn_q};
	assign flow_sat = flow_sum[FLOW_BITS] ? FLOW_MAX : flow_sum[FLOW_BITS-1:0];

	always_comb begin
		res_req = '0;
		par_req = '0;
		stk_req = '0;
		case (state_q)
			S_CLEAR: begin
				res_req.we    = 1'b1;
				res_req.waddr = clr_q;
			end
			S_IDLE: begin
				res_req.we    = in_acc;
				res_req.waddr = {entry.from_vertex, entry.to_vertex};
				res_req.wdata = entry.capacity;
			end
			S_SCAN: begin
				res_req.raddr = {u_q, i_q[VERT_BITS-1:0]};
				stk_req.raddr = top_q - 1'b1;
			end
			S_CHECK: begin
				par_req.we    = (res_rdata != '0);
				par_req.waddr = i_q[VERT_BITS-1:0];
				par_req.wdata = u_q;
				stk_req.we    = (res_rdata != '0) && (i_q[VERT_BITS-1:0] != snk_q)
					&& (top_q != TOP_MAX);
				stk_req.waddr = top_q;
				stk_req.wdata = {u_q, i_inc};
			end
			S_BP, S_AP: begin
				par_req.raddr = v_q;
			end
			S_BPW, S_APW: begin
				res_req.raddr = {par_rdata, v_q};
			end
			S_AW1: begin
				res_req.we    = 1'b1;
				res_req.waddr = {u_q, v_q};
				res_req.wdata = res_rdata - bn_q;
				res_req.raddr = {v_q, u_q};
			end
			S_AW2: begin
				res_req.we    = 1'b1;
				res_req.waddr = {v_q, u_q};
				res_req.wdata = back_sat;
			end
			default: begin
				res_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			vc_q        <= NMAX;
			src_q       <= '0;
			snk_q       <= TOP_MAX;
			u_q         <= '0;
			i_q         <= '0;
			top_q       <= '0;
			seen_q      <= '0;
			v_q         <= '0;
			bn_q        <= CAP_MAX;
			flow_q      <= '0;
			out_valid_q <= 1'b0;
			out_flow_q  <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_VERTEX_COUNT:  vc_q  <= cfg.data;
					CFG_SOURCE_VERTEX: src_q <= cfg.data[VERT_BITS-1:0];
					CFG_SINK_VERTEX:   snk_q <= cfg.data[VERT_BITS-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {RES_ABITS{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && entry.last_entry) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					flow_q <= '0;
					if ({1'b0, src_q} >= n || {1'b0, snk_q} >= n || src_q == snk_q) begin
						out_valid_q <= 1'b1;
						out_flow_q  <= '0;
						clr_q       <= '0;
						state_q     <= S_CLEAR;
					end else begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					seen_q  <= MAX_VERTICES'(1) << src_q;
					top_q   <= '0;
					u_q     <= src_q;
					i_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (i_q >= n) begin
						if (top_q == '0) begin
							out_valid_q <= 1'b1;
							out_flow_q  <= flow_q;
							clr_q       <= '0;
							state_q     <= S_CLEAR;
						end else begin
							top_q   <= top_q - 1'b1;
							state_q <= S_POPLD;
						end
					end else if (seen_q[i_q[VERT_BITS-1:0]]) begin
						i_q <= i_inc;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_SCAN;
					if (res_rdata == '0) begin
						i_q <= i_inc;
					end else if (i_q[VERT_BITS-1:0] == snk_q) begin
						v_q     <= snk_q;
						bn_q    <= CAP_MAX;
						state_q <= S_BP;
					end else begin
						seen_q[i_q[VERT_BITS-1:0]] <= 1'b1;
						if (top_q != TOP_MAX) begin
							top_q <= top_q + 1'b1;
							u_q   <= i_q[VERT_BITS-1:0];
							i_q   <= '0;
						end else begin
							i_q <= i_inc;
						end
					end
				end
				S_POPLD: begin
					u_q     <= stk_rdata[STK_BITS-1:CNT_BITS];
					i_q     <= stk_rdata[CNT_BITS-1:0];
					state_q <= S_SCAN;
				end
				S_BP: begin
					state_q <= S_BPW;
				end
				S_BPW: begin
					u_q     <= par_rdata;
					state_q <= S_BRW;
				end
				S_BRW: begin
					if (res_rdata < bn_q) begin
						bn_q <= res_rdata;
					end
					if (u_q == src_q) begin
						v_q     <= snk_q;
						state_q <= S_AP;
					end else begin
						v_q     <= u_q;
						state_q <= S_BP;
					end
				end
				S_AP: begin
					state_q <= S_APW;
				end
				S_APW: begin
					u_q     <= par_rdata;
					state_q <= S_AW1;
				end
				S_AW1: begin
					state_q <= S_AW2;
				end
				S_AW2: begin
					v_q <= u_q;
					if (u_q == src_q) begin
						flow_q  <= flow_sat;
						state_q <= S_INIT;
					end else begin
						state_q <= S_AP;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/max_flow_dfs_augment_core.sv
// Top level of the max-flow block: the sequencer and its three RAMs.
// Depends on mfd_pkg, mfd_ifs, mfd_ram and mfd_engine.
//
// Usage. Capacity entries arrive on the entry channel, one beat per cycle while
// the block is idle, and overwrite cell (from_vertex, to_vertex) of a 64 x 64
// residual RAM. The beat with last_entry set starts the computation: repeated
// depth-first searches from the source; each one that reaches the sink is followed
// by a bottleneck pass and an update pass along the parent chain. The result beat
// carries the saturated total flow. Registers on the cfg channel (always ready)
// may be written only while the block is idle.
// After reset and after every result the residual RAM is cleared in a pass over
// all 4096 cells, during which no entry beat is taken. A result waits in an output
// register while the receiver stalls; new entries are still taken then, but the
// next last entry is held until the pending result beat has gone.
`timescale 1ns / 1ps
`default_nettype none
module max_flow_dfs_augment_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mfd_entry_if.sink    entry,
	mfd_result_if.source result,
	mfd_cfg_if.sink      cfg
);
	import mfd_pkg::*;

	res_req_t             res_req;
	par_req_t             par_req;
	stk_req_t             stk_req;
	logic [CAP_BITS-1:0]  res_rdata;
	logic [VERT_BITS-1:0] par_rdata;
	logic [STK_BITS-1:0]  stk_rdata;

	mfd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (entry),
		.result    (result),
		.cfg       (cfg),
		.res_req   (res_req),
		.res_rdata (res_rdata),
		.par_req   (par_req),
		.par_rdata (par_rdata),
		.stk_req   (stk_req),
		.stk_rdata (stk_rdata)
	);

	mfd_ram #(.WIDTH(CAP_BITS), .DEPTH(RES_DEPTH)) u_res_ram (
		.clk   (clk),
		.we    (res_req.we),
		.waddr (res_req.waddr),
		.wdata (res_req.wdata),
		.raddr (res_req.raddr),
		.rdata (res_rdata)
	);

	mfd_ram #(.WIDTH(VERT_BITS), .DEPTH(MAX_VERTICES)) u_par_ram (
		.clk   (clk),
		.we    (par_req.we),
		.waddr (par_req.waddr),
		.wdata (par_req.wdata),
		.raddr (par_req.raddr),
		.rdata (par_rdata)
	);

	mfd_ram #(.WIDTH(STK_BITS), .DEPTH(MAX_VERTICES)) u_stk_ram (
		.clk   (clk),
		.we    (stk_req.we),
		.waddr (stk_req.waddr),
		.wdata (stk_req.wdata),
		.raddr (stk_req.raddr),
		.rdata (stk_rdata)
	);
endmodule
`default_nettype wire

FILE: tb/max_flow_dfs_augment_core_tb.sv
// Self-checking testbench for max_flow_dfs_augment_core: capacity entries in, maximum flow out.
// Depends on mfd_pkg, the channel interfaces in mfd_ifs and the block itself.
// A built-in flow solver predicts each result; a monitor compares every result beat in order.
`timescale 1ns / 1ps
module max_flow_dfs_augment_core_tb;
	import mfd_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000000;
	localparam int SETTLE_CYCLES   = 5000;

	typedef struct {
		logic [VERT_BITS-1:0] from_vertex;
		logic [VERT_BITS-1:0] to_vertex;
		logic [CAP_BITS-1:0]  capacity;
		logic                 last_entry;
	} cap_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mfd_entry_if  entry_ch();
	mfd_result_if result_ch();
	mfd_cfg_if    cfg_ch();

	max_flow_dfs_augment_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.entry  (entry_ch.sink),
		.result (result_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always #4 clk = ~clk;

	cap_entry_t            pending_entries[$];
	logic [FLOW_BITS-1:0]  flows_due[$];
	logic [CAP_BITS-1:0]   res_cap[MAX_VERTICES][MAX_VERTICES];
	logic [VERT_BITS-1:0]  tree_parent[MAX_VERTICES];
	bit                    visited[MAX_VERTICES];
	int                    dfs_vert[MAX_VERTICES];
	int                    dfs_next[MAX_VERTICES];
	logic [CNT_BITS-1:0]   cur_count = 7'd64;
	logic [VERT_BITS-1:0]  cur_source = 6'd0;
	logic [VERT_BITS-1:0]  cur_sink = 6'd63;

	int  error_count = 0;
	int  results_checked = 0;
	int  sets_sent = 0;
	int  idle_cycles = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_cnt = 0;
	bit  hold_req = 1'b0;
	bit  idle_on = 1'b1;
	bit  ent_taken = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic bit find_path(int n, int src, int dst);
		int top;
		int u;
		int i;
		top = 0;
		for (int k = 0; k < MAX_VERTICES; k++)
			visited[k] = 1'b0;
		visited[src] = 1'b1;
		dfs_vert[0] = src;
		dfs_next[0] = 0;
		while (top >= 0) begin
			u = dfs_vert[top];
			i = dfs_next[top];
			while (i < n && (visited[i] || res_cap[u][i] == '0))
				i++;
			if (i < n) begin
				dfs_next[top] = i + 1;
				tree_parent[i] = VERT_BITS'(u);
				if (i == dst)
					return 1'b1;
				visited[i] = 1'b1;
				if (top + 1 < MAX_VERTICES) begin
					top++;
					dfs_vert[top] = i;
					dfs_next[top] = 0;
				end
			end else begin
				top--;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [FLOW_BITS-1:0] solve_max_flow();
		int n;
		int s;
		int t;
		int v;
		int u;
		int back;
		logic [CAP_BITS-1:0] pinch;
		longint total;
		n = (cur_count > MAX_VERTICES) ? MAX_VERTICES : cur_count;
		s = cur_source;
		t = cur_sink;
		total = 0;
		if (s < n && t < n && s != t) begin
			while (find_path(n, s, t)) begin
				pinch = CAP_MAX;
				for (v = t; v != s; v = tree_parent[v]) begin
					u = tree_parent[v];
					if (res_cap[u][v] < pinch)
						pinch = res_cap[u][v];
				end
				for (v = t; v != s; v = tree_parent[v]) begin
					u = tree_parent[v];
					res_cap[u][v] = res_cap[u][v] - pinch;
					back = int'(res_cap[v][u]) + int'(pinch);
					res_cap[v][u] = (back > int'(CAP_MAX)) ? CAP_MAX : back[CAP_BITS-1:0];
				end
				total = total + pinch;
				if (total > longint'(FLOW_MAX))
					total = FLOW_MAX;
			end
		end
		for (int a = 0; a < MAX_VERTICES; a++)
			for (int b = 0; b < MAX_VERTICES; b++)
				res_cap[a][b] = '0;
		return total[FLOW_BITS-1:0];
	endfunction

	// Entry acceptance, prediction, result checking and the watchdog.
	always @(posedge clk) begin
		bit any_beat;
		any_beat = 1'b0;
		if (arst_n) begin
			if (entry_ch.valid && entry_ch.ready) begin
				any_beat = 1'b1;
				ent_taken = 1'b1;
				res_cap[entry_ch.from_vertex][entry_ch.to_vertex] = entry_ch.capacity;
				if (entry_ch.last_entry)
					flows_due = {flows_due, solve_max_flow()};
			end
			if (result_ch.valid && result_ch.ready) begin
				any_beat = 1'b1;
				if (flows_due.size() == 0) begin
					$error("unexpected result beat: total_flow actual %0d", result_ch.total_flow);
					error_count++;
				end else begin
					if (result_ch.total_flow !== flows_due[0]) begin
						$error("total_flow mismatch: expected %0d actual %0d",
							flows_due[0], result_ch.total_flow);
						error_count++;
					end
					void'(flows_due.pop_front());
					results_checked++;
				end
			end
			if (cfg_ch.valid && cfg_ch.ready)
				any_beat = 1'b1;
			idle_cycles = any_beat ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("timeout: no beat for %0d cycles", WATCHDOG_CYCLES);
				$display("max_flow_dfs_augment_core_tb: errors");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		bit busy;
		cap_entry_t cur;
		busy = entry_ch.valid && !ent_taken;
		ent_taken = 1'b0;
		if (arst_n && !busy) begin
			if (send_gap > 0) begin
				send_gap--;
				entry_ch.valid <= 1'b0;
			end else if (pending_entries.size() != 0) begin
				cur = pending_entries.pop_front();
				entry_ch.from_vertex <= cur.from_vertex;
				entry_ch.to_vertex   <= cur.to_vertex;
				entry_ch.capacity    <= cur.capacity;
				entry_ch.last_entry  <= cur.last_entry;
				entry_ch.valid       <= 1'b1;
				send_gap = pick_gap();
			end else begin
				entry_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 3000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	task automatic add_entry(int f, int t, int c, bit last);
		cap_entry_t e;
		e.from_vertex = VERT_BITS'(f);
		e.to_vertex   = VERT_BITS'(t);
		e.capacity    = CAP_BITS'(c);
		e.last_entry  = last;
		pending_entries = {pending_entries, e};
		if (last)
			sets_sent++;
	endtask

	task automatic write_reg(logic [CFG_IBITS-1:0] idx, int value);
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_DBITS'(value);
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		if (idx == CFG_VERTEX_COUNT)
			cur_count = CNT_BITS'(value);
		else if (idx == CFG_SOURCE_VERTEX)
			cur_source = VERT_BITS'(value);
		else if (idx == CFG_SINK_VERTEX)
			cur_sink = VERT_BITS'(value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_graph(int n, int s, int t);
		write_reg(CFG_VERTEX_COUNT, n);
		write_reg(CFG_SOURCE_VERTEX, s);
		write_reg(CFG_SINK_VERTEX, t);
	endtask

	// Block goes idle only once every result is back and the clearing pass has run.
	task automatic drain();
		while (pending_entries.size() != 0 || entry_ch.valid || flows_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_random_set(int n);
		int k;
		int sh;
		int span;
		int f;
		int t;
		k = $urandom_range(1, 16);
		sh = $urandom_range(0, 12);
		span = (n < 1) ? 1 : ((n > MAX_VERTICES) ? MAX_VERTICES : n);
		for (int j = 0; j < k; j++) begin
			if ($urandom_range(0, 99) < 85) begin
				f = $urandom_range(0, span - 1);
				t = $urandom_range(0, span - 1);
			end else begin
				f = $urandom_range(0, 63);
				t = $urandom_range(0, 63);
			end
			add_entry(f, t, $urandom_range(0, 15) << sh, j == k - 1);
		end
	endtask

	initial begin
		int n;
		int s;
		int t;
		int r;
		int budget;
		entry_ch.valid = 1'b0;
		entry_ch.from_vertex = '0;
		entry_ch.to_vertex = '0;
		entry_ch.capacity = '0;
		entry_ch.last_entry = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		for (int a = 0; a < MAX_VERTICES; a++)
			for (int b = 0; b < MAX_VERTICES; b++)
				res_cap[a][b] = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Reset settings: self loops, a saturating reverse edge, a two-hop path.
		add_entry(0, 0, 5, 0);
		add_entry(0, 63, 65535, 0);
		add_entry(63, 0, 65535, 0);
		add_entry(0, 10, 4000, 0);
		add_entry(10, 63, 1234, 0);
		add_entry(63, 63, 65535, 0);
		add_entry(5, 6, 0, 1);
		add_entry(0, 63, 0, 1);
		drain();

		// Small graph with entries beyond the vertex count and an overwritten entry.
		set_graph(4, 0, 3);
		add_entry(0, 5, 100, 0);
		add_entry(5, 3, 100, 0);
		add_entry(0, 3, 10, 0);
		add_entry(0, 3, 20, 0);
		add_entry(0, 1, 7, 0);
		add_entry(1, 2, 9, 0);
		add_entry(2, 1, 65535, 0);
		add_entry(2, 3, 42, 1);
		drain();

		set_graph(8, 2, 2);
		add_entry(2, 3, 50, 0);
		add_entry(3, 2, 50, 1);
		drain();
		set_graph(1, 0, 0);
		add_entry(0, 0, 9, 1);
		drain();
		set_graph(0, 0, 1);
		add_entry(0, 1, 9, 1);
		drain();
		set_graph(5, 6, 2);
		add_entry(6, 2, 9, 1);
		drain();
		set_graph(127, 0, 63);
		add_entry(0, 63, 300, 0);
		add_entry(0, 40, 65535, 0);
		add_entry(40, 63, 65535, 1);
		drain();
		set_graph(2, 1, 0);
		add_entry(1, 0, 100, 0);
		add_entry(0, 1, 65535, 1);
		drain();

		budget = 1500;
		for (int ph = 0; budget > 0; ph++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				n = $urandom_range(2, 8);
				s = $urandom_range(0, n - 1);
				t = $urandom_range(0, n - 1);
				if (s == t && $urandom_range(0, 3) != 0)
					t = (s + 1) % n;
			end else if (r < 80) begin
				n = 64;
				s = $urandom_range(0, 63);
				t = $urandom_range(0, 63);
			end else if (r < 90) begin
				case ($urandom_range(0, 4))
					0: n = 0;
					1: n = 1;
					2: n = 65;
					3: n = 127;
					default: n = 64;
				endcase
				s = $urandom_range(0, 63);
				t = $urandom_range(0, 63);
			end else begin
				n = $urandom_range(2, 8);
				s = $urandom_range(0, 63);
				t = $urandom_range(0, 63);
			end
			set_graph(n, s, t);
			idle_on = (ph % 4) != 3;
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == 2) begin
				set_graph(64, 0, 63);
				for (int v = 1; v < 63; v++) begin
					add_entry(0, v, 65535, 0);
					add_entry(v, 63, 65535, 0);
				end
				add_entry(0, 63, 65535, 1);
			end
			while (pending_entries.size() < 100) begin
				add_random_set(n);
			end
			budget -= pending_entries.size();
			drain();
		end

		$display("covered %0d capacity sets, %0d flow results checked, %0d errors",
			sets_sent, results_checked, error_count);
		if (error_count == 0 && flows_due.size() == 0) begin
			$display("max_flow_dfs_augment_core_tb: clean");
		end else begin
			$display("max_flow_dfs_augment_core_tb: errors");
		end
		$finish;
	end
endmodule
